/* hdl/dqs_pkg.sv */
package dqs_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;

  // Internal command codes, after decode
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_NOP        = 3'd6;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic                    found;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage

/* hdl/dqs_ram.sv */
module dqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/dqs_front.sv */
// Front end: decodes requests and buffers them in a two-entry queue.
module dqs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dqs_pkg::ACT_W-1:0]           action,
  input  logic signed [dqs_pkg::VAL_W-1:0]    value,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic                                cmd_valid,
  output dqs_pkg::cmd_t                       cmd,
  input  logic                                cmd_take
);

  dqs_pkg::cmd_t q_cmd [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  dqs_pkg::cmd_t dec;
  logic          push;

  always_comb begin
    dec.value = value;
    unique case (action)
      dqs_pkg::ACT_PUSH_FRONT: dec.op = dqs_pkg::OP_PUSH_FRONT;
      dqs_pkg::ACT_PUSH_BACK:  dec.op = dqs_pkg::OP_PUSH_BACK;
      dqs_pkg::ACT_POP_FRONT:  dec.op = dqs_pkg::OP_POP_FRONT;
      dqs_pkg::ACT_POP_BACK:   dec.op = dqs_pkg::OP_POP_BACK;
      dqs_pkg::ACT_SEARCH:     dec.op = dqs_pkg::OP_SEARCH;
      dqs_pkg::ACT_CLEAR:      dec.op = dqs_pkg::OP_CLEAR;
      default:                 dec.op = dqs_pkg::OP_NOP;
    endcase
  end

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q_cmd[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !cmd_take) begin
        fill <= fill + 2'd1;
      end else if (!push && cmd_take) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* hdl/dqs_back.sv */
// Back end: executes decoded commands against the ring store.
module dqs_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  dqs_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          out_valid,
  input  logic          out_stall,
  output dqs_pkg::res_t res
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]                       state, state_next;
  logic [AW-1:0]                    front, front_next;
  logic [CW-1:0]                    elem_count, count_next;
  logic [AW-1:0]                    srch_idx, idx_next;
  logic signed [dqs_pkg::VAL_W-1:0] srch_val, val_next;
  logic                             ram_wr_en, ram_rd_en;
  logic [AW-1:0]                    ram_wr_addr, ram_rd_addr;
  logic [dqs_pkg::VAL_W-1:0]        ram_wr_data, ram_rd_data;
  logic                             out_free, res_load;
  dqs_pkg::res_t                    res_next;
  logic [CW-1:0]                    next_idx_c;
  logic [CW-1:0]                    count_dec;
  logic [AW-1:0]                    front_dec;
  logic [AW+dqs_pkg::POS_W-1:0]     pos_ext;
  logic [CW+dqs_pkg::CNT_W-1:0]     cnt_ext;

  // Ring address at a distance from the front; off < DEPTH
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  dqs_ram #(
    .WIDTH (dqs_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_free   = !out_valid || !out_stall;
  assign next_idx_c = CW'(srch_idx) + CW'(1);
  assign count_dec  = elem_count - CW'(1);
  assign front_dec  = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);

  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = elem_count;
    idx_next    = srch_idx;
    val_next    = srch_val;
    ram_wr_en   = 1'b0;
    ram_wr_addr = front;
    ram_wr_data = cmd.value;
    ram_rd_en   = 1'b0;
    ram_rd_addr = front;
    cmd_take    = 1'b0;
    res_load    = 1'b0;
    res_next    = '0;
    pos_ext     = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          unique case (cmd.op)
            dqs_pkg::OP_PUSH_FRONT: begin
              res_load = 1'b1;
              if (elem_count == DEPTH_C) begin
                res_next.status = dqs_pkg::ST_FULL;
              end else begin
                front_next  = front_dec;
                ram_wr_en   = 1'b1;
                ram_wr_addr = front_dec;
                count_next  = elem_count + CW'(1);
              end
            end
            dqs_pkg::OP_PUSH_BACK: begin
              res_load = 1'b1;
              if (elem_count == DEPTH_C) begin
                res_next.status = dqs_pkg::ST_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ring_at(front, elem_count[AW-1:0]);
                count_next  = elem_count + CW'(1);
              end
            end
            dqs_pkg::OP_POP_FRONT: begin
              if (elem_count == '0) begin
                res_load        = 1'b1;
                res_next.status = dqs_pkg::ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = front;
                front_next  = ring_at(front, AW'(1));
                count_next  = count_dec;
                state_next  = S_POP;
              end
            end
            dqs_pkg::OP_POP_BACK: begin
              if (elem_count == '0) begin
                res_load        = 1'b1;
                res_next.status = dqs_pkg::ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ring_at(front, count_dec[AW-1:0]);
                count_next  = count_dec;
                state_next  = S_POP;
              end
            end
            dqs_pkg::OP_SEARCH: begin
              if (elem_count == '0) begin
                res_load = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = front;
                idx_next    = '0;
                val_next    = cmd.value;
                state_next  = S_SRCH;
              end
            end
            dqs_pkg::OP_CLEAR: begin
              res_load   = 1'b1;
              front_next = '0;
              count_next = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_load               = 1'b1;
        res_next.removed_value = ram_rd_data;
        state_next             = S_IDLE;
      end
      S_SRCH: begin
        // read data belongs to srch_idx; next read issued back to back
        if (ram_rd_data == srch_val) begin
          res_load                = 1'b1;
          res_next.found          = 1'b1;
          pos_ext                 = {{dqs_pkg::POS_W{1'b0}}, srch_idx};
          res_next.found_position = pos_ext[dqs_pkg::POS_W-1:0];
          state_next              = S_IDLE;
        end else if (next_idx_c == elem_count) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ring_at(front, next_idx_c[AW-1:0]);
          idx_next    = next_idx_c[AW-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    cnt_ext        = {{dqs_pkg::CNT_W{1'b0}}, count_next};
    res_next.count = cnt_ext[dqs_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      elem_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front      <= front_next;
      elem_count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    srch_idx <= idx_next;
    srch_val <= val_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= DEPTH_C)
    else $error("element count beyond depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    res_load && (res_next.status == dqs_pkg::ST_FULL) |-> elem_count == DEPTH_C)
    else $error("full status with room left");

  a_pop_follows_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(state) == S_IDLE) && !cmd_take)
    else $error("pop completion out of sequence");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (CW'(srch_idx) < elem_count))
    else $error("search index past count");

  a_removed_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    res_load && (res_next.removed_value != '0) |-> res_next.status == dqs_pkg::ST_OK)
    else $error("removed value on failed request");

endmodule

/* hdl/deque_with_search.sv */
// Bounded double-ended queue of signed 32-bit values, with a linear search.
// Input channel (in_valid / in_stall): action and value. Actions are push
// front, push back, pop front, pop back, search and clear; other codes are
// no-ops. Output channel (out_valid / out_stall): one result per request,
// carrying status, removed_value, found, found_position and count.
// Requests are decoded into a two-entry queue, so the input side keeps
// taking requests while a result waits at the output.
// Push, clear, no-op and a search of an empty queue load the result as the
// back end takes the request; a pop loads it from S_POP after the store
// read; a search compares one entry per cycle in S_SRCH until a match or
// the count. The ring store has one read port: pushes and clears run 1 per
// cycle while out_stall is low; a pop or a search holds the back end.
// Reset (rst, synchronous) empties the queue and drops any pending request
// or result; store contents are not cleared, only entries inside the count
// are ever read. While out_stall is high the result register holds and the
// back end waits; the input queue fills and then raises in_stall.
// Push on a full queue returns full status, pop on an empty queue returns
// empty status; neither changes the contents.
module deque_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dqs_pkg::ACT_W-1:0]           action,
  input  logic signed [dqs_pkg::VAL_W-1:0]    value,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic [dqs_pkg::STAT_W-1:0]          status,
  output logic signed [dqs_pkg::VAL_W-1:0]    removed_value,
  output logic                                found,
  output logic [dqs_pkg::POS_W-1:0]           found_position,
  output logic [dqs_pkg::CNT_W-1:0]           count,
  output logic                                out_valid,
  input  logic                                out_stall
);

  logic          cmd_valid;
  logic          cmd_take;
  dqs_pkg::cmd_t cmd;
  dqs_pkg::res_t res;

  // decode + request queue
  dqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .value     (value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // execution against the ring store, result register
  dqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign status         = res.status;
  assign removed_value  = res.removed_value;
  assign found          = res.found;
  assign found_position = res.found_position;
  assign count          = res.count;

endmodule
